[src/mat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_pkg
// Shared constants, codes and types of the multi-alarm timer table.
// ----------------------------------------------------------------------------
package mat_pkg;

	localparam int NUM_ALARMS = 8;
	localparam int TICK_W     = 16;
	localparam int ID_W       = 4;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 3;
	localparam int ALARM_W    = 3;
	localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam int CFG_AW     = 4;
	localparam int CFG_DW     = 32;
	localparam int DIV_W      = TICK_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	typedef logic [TICK_W-1:0] tick_t;

	localparam tick_t TICK_ONES = {TICK_W{1'b1}};

	localparam logic KIND_FINAL  = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_SET_REL  = 3'd1,
		OP_SET_ABS  = 3'd2,
		OP_CANCEL   = 3'd3,
		OP_GET      = 3'd4,
		OP_GET_BASE = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_ID    = 3'd1,
		ST_BAD_VALUE = 3'd2,
		ST_ARMED     = 3'd3,
		ST_NOT_ARMED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_COUNTER_MAX    = 2'd0,
		REG_MIN_CYCLE      = 2'd1,
		REG_TICKS_PER_BASE = 2'd2,
		REG_EXT_CHECKS     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		tick_t counter_max;
		tick_t min_cycle;
		tick_t ticks_per_base;
		logic  extended_checks;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD,
		S_CNT,
		S_CNT_WAIT,
		S_SCAN,
		S_DIV_WAIT,
		S_REPORT,
		S_FINAL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic cnt_start;
		logic cnt_load;
		logic cnt_clear;
		logic scan_clr;
		logic scan_next;
		logic dec;
		logic shot;
		logic fire_start;
		logic fire_load;
		logic cmd_done;
		logic tick_done;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic in_tick;
		logic cm_zero;
		logic alarm_en;
		logic rem_gt;
		logic cyc_zero;
		logic idx_last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

[src/mat_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module mat_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mat_pkg::CFG_AW-1:0] paddr,
	input  logic [mat_pkg::CFG_DW-1:0] pwdata,
	output logic [mat_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output mat_pkg::cfg_t              cfg
);
	import mat_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counter_max     <= TICK_ONES;
			cfg_q.min_cycle       <= tick_t'(1);
			cfg_q.ticks_per_base  <= tick_t'(1);
			cfg_q.extended_checks <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COUNTER_MAX:    cfg_q.counter_max     <= pwdata[TICK_W-1:0];
				REG_MIN_CYCLE:      cfg_q.min_cycle       <= pwdata[TICK_W-1:0];
				REG_TICKS_PER_BASE: cfg_q.ticks_per_base  <= pwdata[TICK_W-1:0];
				REG_EXT_CHECKS:     cfg_q.extended_checks <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COUNTER_MAX:    prdata = CFG_DW'(cfg_q.counter_max);
			REG_MIN_CYCLE:      prdata = CFG_DW'(cfg_q.min_cycle);
			REG_TICKS_PER_BASE: prdata = CFG_DW'(cfg_q.ticks_per_base);
			REG_EXT_CHECKS:     prdata = CFG_DW'(cfg_q.extended_checks);
			default:            prdata = '0;
		endcase
	end

endmodule

[src/mat_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_div
// Restoring divider, one quotient bit per cycle, shared by the counter
// wrap and the cyclic reload.
// ----------------------------------------------------------------------------
module mat_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mat_pkg::DIV_W-1:0] dividend,
	input  mat_pkg::tick_t            divisor,
	output logic                      done,
	output logic [mat_pkg::DIV_W-1:0] quotient,
	output mat_pkg::tick_t            remainder
);
	import mat_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [DIV_W-1:0]     quo_q;
	tick_t                rem_q;
	tick_t                dvs_q;
	logic [DIV_W-1:0]     trial;
	logic [DIV_W-1:0]     diff;
	logic                 fits;
	logic                 last_step;

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign diff      = trial - {1'b0, dvs_q};
	assign fits      = trial >= {1'b0, dvs_q};
	assign last_step = step_q == DIV_CNT_W'(DIV_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

endmodule

[src/mat_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_datapath
// Alarm table, tick counter, divider and result register.
// ----------------------------------------------------------------------------
module mat_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mat_pkg::cfg_t                cfg,
	input  mat_pkg::ctl_t                ctl,
	output mat_pkg::sts_t                sts,
	input  logic [mat_pkg::OP_W-1:0]     opcode,
	input  logic [mat_pkg::ID_W-1:0]     alarm_id,
	input  mat_pkg::tick_t               tick_value,
	input  mat_pkg::tick_t               cycle_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [mat_pkg::STATUS_W-1:0] status,
	output logic                         report_kind,
	output logic [mat_pkg::ALARM_W-1:0]  expired_alarm,
	output mat_pkg::tick_t               fire_count,
	output mat_pkg::tick_t               value_out,
	output mat_pkg::tick_t               min_cycle_out,
	output mat_pkg::tick_t               ticks_per_base_out,
	output logic                         last
);
	import mat_pkg::*;

	// latched beat
	logic [OP_W-1:0] op_q;
	logic [ID_W-1:0] id_q;
	tick_t           tv_q;
	tick_t           cv_q;

	// alarm table
	logic [NUM_ALARMS-1:0] en_q;
	tick_t                 rem_q [NUM_ALARMS];
	tick_t                 cyc_q [NUM_ALARMS];
	tick_t                 cnt_q;
	logic [IDX_W-1:0]      idx_q;
	tick_t                 earliest_q;

	// result register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                kind_q;
	logic [ALARM_W-1:0]  expired_q;
	tick_t               fires_q;
	tick_t               value_q;
	tick_t               minc_q;
	tick_t               tpb_q;
	logic                last_q;

	tick_t            rem_rd;
	tick_t            cyc_rd;
	logic             en_rd;
	logic [DIV_W-1:0] div_dividend;
	tick_t            div_divisor;
	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	tick_t            div_rem;
	logic [DIV_W-1:0] fires_inc;
	tick_t            fires_sat;
	tick_t            reload_rem;
	tick_t            scan_rem;
	logic             scan_wr;
	logic             bad_id;
	logic             bad_value;
	tick_t            abs_dist;
	logic             arm;
	logic             disarm;
	logic [STATUS_W-1:0] res_status;
	tick_t            res_value;
	tick_t            res_minc;
	tick_t            res_tpb;
	logic             out_load;

	assign rem_rd = rem_q[idx_q];
	assign cyc_rd = cyc_q[idx_q];
	assign en_rd  = en_q[idx_q];

	// divider operands: counter wrap or distance past the alarm
	assign div_start    = ctl.cnt_start || ctl.fire_start;
	assign div_dividend = ctl.cnt_start ? ({1'b0, cnt_q} + {1'b0, tv_q})
	                                    : {1'b0, tv_q - rem_rd};
	assign div_divisor  = ctl.cnt_start ? cfg.counter_max : cyc_rd;

	mat_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign fires_inc  = div_quo + DIV_W'(1);
	assign fires_sat  = fires_inc[DIV_W-1] ? TICK_ONES : fires_inc[TICK_W-1:0];
	// rem + n*cycle - elapsed equals cycle minus the division remainder
	assign reload_rem = cyc_rd - div_rem;

	always_comb begin
		scan_rem = rem_rd - tv_q;
		if (ctl.shot) begin
			scan_rem = '0;
		end else if (ctl.fire_load) begin
			scan_rem = reload_rem;
		end
	end
	assign scan_wr = ctl.dec || ctl.shot || ctl.fire_load;

	// command checks
	assign bad_id    = {1'b0, id_q} >= (ID_W + 1)'(NUM_ALARMS);
	assign bad_value = cfg.extended_checks && ((tv_q > cfg.counter_max) ||
		((cv_q != '0) && ((cv_q > cfg.counter_max) || (cv_q < cfg.min_cycle))));
	assign abs_dist  = (tv_q > cnt_q) ? (tv_q - cnt_q) : (tv_q + cfg.counter_max - cnt_q);

	always_comb begin
		arm        = 1'b0;
		disarm     = 1'b0;
		res_status = ST_OK;
		res_value  = '0;
		res_minc   = '0;
		res_tpb    = '0;
		if (op_q == OP_GET_BASE) begin
			if (bad_id) begin
				res_status = ST_BAD_ID;
			end else begin
				res_value = cfg.counter_max;
				res_minc  = cfg.min_cycle;
				res_tpb   = cfg.ticks_per_base;
			end
		end else if ((op_q == OP_SET_REL) || (op_q == OP_SET_ABS) ||
		             (op_q == OP_CANCEL) || (op_q == OP_GET)) begin
			if (bad_id) begin
				res_status = ST_BAD_ID;
			end else begin
				unique case (op_q)
					OP_SET_REL, OP_SET_ABS: begin
						if (bad_value) begin
							res_status = ST_BAD_VALUE;
						end else if (en_rd) begin
							res_status = ST_ARMED;
						end else begin
							arm = 1'b1;
						end
					end
					OP_CANCEL: begin
						if (!en_rd) begin
							res_status = ST_NOT_ARMED;
						end else begin
							disarm = 1'b1;
						end
					end
					default: begin
						if (!en_rd) begin
							res_status = ST_NOT_ARMED;
						end else begin
							res_value = rem_rd;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q <= opcode;
			id_q <= alarm_id;
			tv_q <= tick_value;
			cv_q <= cycle_value;
		end
		if (ctl.cmd_done && arm) begin
			rem_q[idx_q] <= (op_q == OP_SET_ABS) ? abs_dist : tv_q;
			cyc_q[idx_q] <= cv_q;
		end else if (scan_wr) begin
			rem_q[idx_q] <= scan_rem;
		end
		if (ctl.scan_clr) begin
			earliest_q <= TICK_ONES;
		end else if (scan_wr && (scan_rem < earliest_q)) begin
			earliest_q <= scan_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctl.cmd_done && arm) begin
				en_q[idx_q] <= 1'b1;
			end else if ((ctl.cmd_done && disarm) || ctl.shot) begin
				en_q[idx_q] <= 1'b0;
			end
			if (ctl.cnt_clear) begin
				cnt_q <= '0;
			end else if (ctl.cnt_load) begin
				cnt_q <= div_rem;
			end
			if (ctl.latch) begin
				idx_q <= alarm_id[IDX_W-1:0];
			end else if (ctl.scan_clr) begin
				idx_q <= '0;
			end else if (ctl.scan_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// result register
	assign out_load = ctl.cmd_done || ctl.tick_done || ctl.shot || ctl.fire_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= ST_OK;
			kind_q    <= KIND_FINAL;
			expired_q <= '0;
			fires_q   <= '0;
			value_q   <= '0;
			minc_q    <= '0;
			tpb_q     <= '0;
			last_q    <= 1'b1;
			if (ctl.cmd_done) begin
				status_q <= res_status;
				value_q  <= res_value;
				minc_q   <= res_minc;
				tpb_q    <= res_tpb;
			end else if (ctl.tick_done) begin
				value_q <= earliest_q;
			end else begin
				kind_q    <= KIND_EXPIRY;
				expired_q <= ALARM_W'(idx_q);
				fires_q   <= ctl.shot ? tick_t'(1) : fires_sat;
				value_q   <= scan_rem;
				last_q    <= 1'b0;
			end
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign status             = status_q;
	assign report_kind        = kind_q;
	assign expired_alarm      = expired_q;
	assign fire_count         = fires_q;
	assign value_out          = value_q;
	assign min_cycle_out      = minc_q;
	assign ticks_per_base_out = tpb_q;
	assign last               = last_q;

	assign sts.in_tick  = opcode == OP_TICK;
	assign sts.cm_zero  = cfg.counter_max == '0;
	assign sts.alarm_en = en_rd;
	assign sts.rem_gt   = rem_rd > tv_q;
	assign sts.cyc_zero = cyc_rd == '0;
	assign sts.idx_last = idx_q == IDX_W'(NUM_ALARMS - 1);
	assign sts.div_done = div_done;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> sts.out_free)
		else $error("result register loaded while a beat is pending");

	a_counter_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_load |=> cnt_q < cfg.counter_max)
		else $error("counter not below counter_max after wrap");

endmodule

[src/mat_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_ctrl
// Sequencer: runs one command, or one tick with its alarm scan.
// ----------------------------------------------------------------------------
module mat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  mat_pkg::sts_t sts,
	output mat_pkg::ctl_t ctl
);
	import mat_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = sts.in_tick ? S_CNT : S_CMD;
				end
			end
			S_CMD: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_CNT: begin
				state_d = sts.cm_zero ? S_SCAN : S_CNT_WAIT;
			end
			S_CNT_WAIT: begin
				if (sts.div_done) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.alarm_en || sts.rem_gt || (sts.cyc_zero && sts.out_free)) begin
					if (sts.idx_last) begin
						state_d = S_FINAL;
					end
				end else if (!sts.cyc_zero) begin
					state_d = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (sts.out_free) begin
					state_d = sts.idx_last ? S_FINAL : S_SCAN;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				ctl.latch = cmd_valid;
			end
			S_CMD: begin
				ctl.cmd_done = sts.out_free;
			end
			S_CNT: begin
				ctl.scan_clr  = 1'b1;
				ctl.cnt_clear = sts.cm_zero;
				ctl.cnt_start = !sts.cm_zero;
			end
			S_CNT_WAIT: begin
				ctl.cnt_load = sts.div_done;
			end
			S_SCAN: begin
				if (!sts.alarm_en) begin
					ctl.scan_next = !sts.idx_last;
				end else if (sts.rem_gt) begin
					ctl.dec       = 1'b1;
					ctl.scan_next = !sts.idx_last;
				end else if (sts.cyc_zero) begin
					ctl.shot      = sts.out_free;
					ctl.scan_next = sts.out_free && !sts.idx_last;
				end else begin
					ctl.fire_start = 1'b1;
				end
			end
			S_DIV_WAIT: ;
			S_REPORT: begin
				ctl.fire_load = sts.out_free;
				ctl.scan_next = sts.out_free && !sts.idx_last;
			end
			S_FINAL: begin
				ctl.tick_done = sts.out_free;
			end
			default: ;
		endcase
	end

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.cmd_done, ctl.tick_done, ctl.shot, ctl.fire_load}))
		else $error("more than one result loaded in a cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cmd_valid) |=> state_q != S_IDLE)
		else $error("sequencer idle right after accepting a beat");

endmodule

[src/multi_alarm_timer_table_core.sv]
`timescale 1ns / 1ps
// a non-tick command gets a single result beat, registered once the output is free
// tick: a counter wrap divide (skipped when counter_max is zero), then a scan step per
//   alarm, using the 17-step shared divider for a cyclic expiry, then the final beat
// one command beat at a time: a new beat is taken only once the last result is loaded
// reset clears all alarm enables, the counter and the settings to their defaults at once
// ----------------------------------------------------------------------------
// multi_alarm_timer_table_core
// Alarm table on one shared tick counter with an APB-style settings port.
// ----------------------------------------------------------------------------
module multi_alarm_timer_table_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mat_pkg::CFG_AW-1:0]   paddr,
	input  logic [mat_pkg::CFG_DW-1:0]   pwdata,
	output logic [mat_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [mat_pkg::OP_W-1:0]     opcode,
	input  logic [mat_pkg::ID_W-1:0]     alarm_id,
	input  mat_pkg::tick_t               tick_value,
	input  mat_pkg::tick_t               cycle_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [mat_pkg::STATUS_W-1:0] status,
	output logic                         report_kind,
	output logic [mat_pkg::ALARM_W-1:0]  expired_alarm,
	output mat_pkg::tick_t               fire_count,
	output mat_pkg::tick_t               value_out,
	output mat_pkg::tick_t               min_cycle_out,
	output mat_pkg::tick_t               ticks_per_base_out,
	output logic                         last
);
	import mat_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	mat_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	mat_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.ctl                (ctl),
		.sts                (sts),
		.opcode             (opcode),
		.alarm_id           (alarm_id),
		.tick_value         (tick_value),
		.cycle_value        (cycle_value),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.report_kind        (report_kind),
		.expired_alarm      (expired_alarm),
		.fire_count         (fire_count),
		.value_out          (value_out),
		.min_cycle_out      (min_cycle_out),
		.ticks_per_base_out (ticks_per_base_out),
		.last               (last)
	);

endmodule
